// File: rtl/rtbd_pkg.sv
// Package: shared types and constants for the RGB tile box downscaler.
`timescale 1ns / 1ps
`default_nettype none

package rtbd_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned PairW       = 9;
  localparam int unsigned TileWidthW  = 9;
  localparam int unsigned TileHeightW = 13;
  localparam int unsigned RowW        = 12;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 13;

  localparam logic [TileHeightW-1:0] MaxTileHeight = 13'd4096;
  localparam logic [TileHeightW-1:0] MinTileDim    = 13'd2;

  localparam logic [TileWidthW-1:0]  TileWidthRst  = 9'd256;
  localparam logic [TileHeightW-1:0] TileHeightRst = 13'd256;
  localparam logic [TileWidthW-1:0]  ValidColsRst  = 9'd256;
  localparam logic [TileHeightW-1:0] ValidRowsRst  = 13'd4096;
  localparam logic [ChanW-1:0]       PaddingRst    = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TILE_WIDTH    = 3'd0,
    CFG_TILE_HEIGHT   = 3'd1,
    CFG_VALID_COLS    = 3'd2,
    CFG_VALID_ROWS    = 3'd3,
    CFG_PADDING_VALUE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             tile_done;
  } pixel_out_t;

  typedef struct packed {
    logic [PairW-1:0] red;
    logic [PairW-1:0] green;
    logic [PairW-1:0] blue;
  } pair_sum_t;

endpackage

`default_nettype wire

// File: rtl/rgb_tile_box_downscale.sv
// Top level: 2x2 box-filter downscaler for one RGB source tile.
`timescale 1ns / 1ps
`default_nettype none

// Takes one source pixel per cycle in raster order and, after every odd
// column of an odd row, emits the per-channel floor of the mean of the 2x2
// block in the next cycle from the output register; tile_done marks the last
// output of the tile. A new pixel is accepted every cycle; the only stall is
// a pixel that completes a block while the previous result is still held.
// The line store holds MAX_TILE_WIDTH/2 horizontal pair sums, written once per
// pair on even rows and read on every even column, so its single registered
// read port sets no limit on rate. It needs no clearing pass.
// Columns at or beyond valid_cols and rows at or beyond valid_rows are
// replaced by padding_value. Write configuration only while idle.
module rgb_tile_box_downscale #(
  parameter int unsigned MAX_TILE_WIDTH = 256
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire rtbd_pkg::pixel_in_t   in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output rtbd_pkg::pixel_out_t       out_data_o,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire [rtbd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [rtbd_pkg::CfgDataW-1:0] cfg_data_i
);
  import rtbd_pkg::*;

  localparam int unsigned ColW   = (MAX_TILE_WIDTH > 2) ? $clog2(MAX_TILE_WIDTH) : 1;
  localparam int unsigned SlotW  = (ColW > 1) ? ColW - 1 : 1;
  localparam int unsigned Depth  = MAX_TILE_WIDTH / 2;
  localparam int unsigned CmpW   = (ColW + 1 > TileHeightW) ? ColW + 1 : TileHeightW;
  localparam logic [CmpW-1:0] MaxWidth = CmpW'(MAX_TILE_WIDTH & ~1);

  logic [TileWidthW-1:0]  tile_width_q;
  logic [TileHeightW-1:0] tile_height_q;
  logic [TileWidthW-1:0]  valid_cols_q;
  logic [TileHeightW-1:0] valid_rows_q;
  logic [ChanW-1:0]       padding_q;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  pair_sum_t       pair_sum_q;
  pair_sum_t       above_q;
  pair_sum_t       line_mem [Depth];
  logic            out_valid_q;
  pixel_out_t      out_data_q;

  logic [CmpW-1:0]        width_eff;
  logic [CmpW-1:0]        width_raw;
  logic [TileHeightW-1:0] height_eff;
  logic [TileHeightW-1:0] height_raw;
  logic [CmpW-1:0]        col_next;
  logic [TileHeightW-1:0] row_next;
  logic                   row_end;
  logic                   tile_end;
  logic                   pad;
  logic                   emit;
  logic                   in_fire;
  logic [SlotW-1:0]       slot;
  pair_sum_t              pixel;
  pair_sum_t              pair;
  logic [PairW:0]         sum_r, sum_g, sum_b;
  pixel_out_t             result;

  always_comb begin
    width_raw = CmpW'(tile_width_q) & ~CmpW'(1);
    if (width_raw < CmpW'(MinTileDim)) begin
      width_eff = CmpW'(MinTileDim);
    end else if (width_raw > MaxWidth) begin
      width_eff = MaxWidth;
    end else begin
      width_eff = width_raw;
    end
    height_raw = tile_height_q & ~TileHeightW'(1);
    if (height_raw < MinTileDim) begin
      height_eff = MinTileDim;
    end else if (height_raw > MaxTileHeight) begin
      height_eff = MaxTileHeight;
    end else begin
      height_eff = height_raw;
    end
  end

  assign col_next = CmpW'(col_q) + CmpW'(1);
  assign row_next = TileHeightW'(row_q) + TileHeightW'(1);
  assign row_end  = (col_next >= width_eff);
  assign tile_end = row_end && (row_next >= height_eff);
  assign pad      = (CmpW'(col_q) >= CmpW'(valid_cols_q)) ||
                    (TileHeightW'(row_q) >= valid_rows_q);
  assign slot     = SlotW'(col_q >> 1);
  assign emit     = col_q[0] && row_q[0];

  assign in_ready_o  = !(emit && out_valid_q && !out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    pixel.red   = PairW'(pad ? padding_q : in_data_i.red_in);
    pixel.green = PairW'(pad ? padding_q : in_data_i.green_in);
    pixel.blue  = PairW'(pad ? padding_q : in_data_i.blue_in);
    pair.red    = pair_sum_q.red + pixel.red;
    pair.green  = pair_sum_q.green + pixel.green;
    pair.blue   = pair_sum_q.blue + pixel.blue;
    sum_r       = (PairW + 1)'(above_q.red) + (PairW + 1)'(pair.red);
    sum_g       = (PairW + 1)'(above_q.green) + (PairW + 1)'(pair.green);
    sum_b       = (PairW + 1)'(above_q.blue) + (PairW + 1)'(pair.blue);
    result.red_out   = sum_r[PairW:2];
    result.green_out = sum_g[PairW:2];
    result.blue_out  = sum_b[PairW:2];
    result.tile_done = tile_end;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (row_end) begin
        col_d = '0;
        row_d = tile_end ? '0 : row_next[RowW-1:0];
      end else begin
        col_d = col_next[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_width_q  <= TileWidthRst;
      tile_height_q <= TileHeightRst;
      valid_cols_q  <= ValidColsRst;
      valid_rows_q  <= ValidRowsRst;
      padding_q     <= PaddingRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TILE_WIDTH:    tile_width_q  <= cfg_data_i[TileWidthW-1:0];
        CFG_TILE_HEIGHT:   tile_height_q <= cfg_data_i;
        CFG_VALID_COLS:    valid_cols_q  <= cfg_data_i[TileWidthW-1:0];
        CFG_VALID_ROWS:    valid_rows_q  <= cfg_data_i;
        CFG_PADDING_VALUE: padding_q     <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold pair sum and the line store entry for the odd column, write the line store on even rows, register the output
  always_ff @(posedge clk_i) begin
    if (in_fire && !col_q[0]) begin
      pair_sum_q <= pixel;
      above_q    <= line_mem[slot];
    end
    if (in_fire && col_q[0] && !row_q[0]) begin
      line_mem[slot] <= pair;
    end
    if (in_fire && emit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
